// ===== src/plid_pkg.sv =====
// Package with shared types and constants for the positional list.
`timescale 1ns / 1ps

package plid_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned CmpW     = ((CntW > 8) ? CntW : 8) + 1;
  localparam int unsigned DataW    = 32;

  typedef enum logic [1:0] {
    ReqAppend = 2'd0,
    ReqInsert = 2'd1,
    ReqDelete = 2'd2,
    ReqNop    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StBadPos = 2'd1,
    StEmpty  = 2'd2,
    StFull   = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic signed [31:0] item_value;
    logic [7:0]        position;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic signed [31:0] removed_value;
    logic [6:0]        list_length;
  } rsp_t;

endpackage

// ===== src/plid_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module plid_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/positional_list_insert_delete.sv =====
// Top level of the positional list: request sequencer, entry RAM and result register.
//
//   Channel | Direction | Handshake                  | Word
//   in      | input     | in_valid_i / in_ready_o    | plid_pkg::req_t
//   out     | output    | out_valid_o / out_ready_i  | plid_pkg::rsp_t
//
// Every moved entry is read from the entry RAM and written back one slot on (insert) or back
// (delete). An insert at position p moves the entries from p onward, then writes the new item;
// an append only writes it; a delete moves the entries behind p; a rejected request only reports.
// Reset clears the count and the sequencer; the RAM contents are left as they are.
// A result that is not taken holds the sequencer in its final state until the output is free.
`timescale 1ns / 1ps

module positional_list_insert_delete (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  plid_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output plid_pkg::rsp_t  out_data_o
);

  typedef enum logic [4:0] {
    SIdle = 5'b00001,
    SRead = 5'b00010,
    SWrite = 5'b00100,
    SPut  = 5'b01000,
    SFin  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [plid_pkg::CntW-1:0]  count_q, count_d;
  logic [plid_pkg::CntW-1:0]  ptr_q, ptr_d;
  logic [plid_pkg::CntW-1:0]  slot_q, slot_d;
  logic                       del_q, del_d;
  logic                       grow_q, grow_d;
  logic                       shrink_q, shrink_d;
  logic [1:0]                 status_q, status_d;
  logic [plid_pkg::DataW-1:0] value_q, value_d;
  logic [plid_pkg::DataW-1:0] removed_q, removed_d;
  logic                       out_valid_q, out_valid_d;
  plid_pkg::rsp_t             out_data_q, out_data_d;

  logic                       ram_we;
  logic [plid_pkg::CntW-1:0]  ram_waddr;
  logic [plid_pkg::DataW-1:0] ram_wdata;
  logic [plid_pkg::DataW-1:0] ram_rdata;

  logic [plid_pkg::CmpW-1:0]  pos_ext;
  logic [plid_pkg::CmpW-1:0]  cnt_ext;
  logic [plid_pkg::CntW-1:0]  pos_slot;
  logic [plid_pkg::CntW-1:0]  new_count;
  logic                       full;
  logic                       out_free;

  assign pos_ext  = plid_pkg::CmpW'(in_data_i.position);
  assign cnt_ext  = plid_pkg::CmpW'(count_q);
  assign pos_slot = plid_pkg::CntW'(pos_ext - plid_pkg::CmpW'(1));
  assign full     = (cnt_ext >= plid_pkg::CmpW'(plid_pkg::Capacity));
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == SIdle);

  assign new_count = grow_q   ? count_q + plid_pkg::CntW'(1) :
                     shrink_q ? count_q - plid_pkg::CntW'(1) : count_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    slot_d      = slot_q;
    del_d       = del_q;
    grow_d      = grow_q;
    shrink_d    = shrink_q;
    status_d    = status_q;
    value_d     = value_q;
    removed_d   = removed_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q;
    ram_wdata   = ram_rdata;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          value_d   = in_data_i.item_value;
          removed_d = '0;
          status_d  = plid_pkg::StOk;
          grow_d    = 1'b0;
          shrink_d  = 1'b0;
          del_d     = 1'b0;
          state_d   = SFin;
          unique case (plid_pkg::req_e'(in_data_i.req_type))
            plid_pkg::ReqAppend: begin
              if (full) begin
                status_d = plid_pkg::StFull;
              end else begin
                grow_d = 1'b1;
                slot_d = count_q;
                ptr_d  = count_q - plid_pkg::CntW'(1);
                state_d = SPut;
              end
            end
            plid_pkg::ReqInsert: begin
              if (pos_ext == '0 || pos_ext > cnt_ext + plid_pkg::CmpW'(1)) begin
                status_d = plid_pkg::StBadPos;
              end else if (full) begin
                status_d = plid_pkg::StFull;
              end else begin
                grow_d = 1'b1;
                slot_d = pos_slot;
                ptr_d  = count_q - plid_pkg::CntW'(1);
                state_d = (pos_slot == count_q) ? SPut : SRead;
              end
            end
            plid_pkg::ReqDelete: begin
              if (count_q == '0) begin
                status_d = plid_pkg::StEmpty;
              end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                status_d = plid_pkg::StBadPos;
              end else begin
                shrink_d = 1'b1;
                del_d    = 1'b1;
                slot_d   = pos_slot;
                ptr_d    = pos_slot;
                state_d  = SRead;
              end
            end
            plid_pkg::ReqNop: begin
              state_d = SFin;
            end
            default: begin
              state_d = SFin;
            end
          endcase
        end
      end
      SRead: begin
        state_d = SWrite;
      end
      SWrite: begin
        if (del_q) begin
          if (ptr_q == slot_q) begin
            removed_d = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = ptr_q - plid_pkg::CntW'(1);
          end
          if (ptr_q + plid_pkg::CntW'(1) < count_q) begin
            ptr_d   = ptr_q + plid_pkg::CntW'(1);
            state_d = SRead;
          end else begin
            state_d = SFin;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q + plid_pkg::CntW'(1);
          if (ptr_q == slot_q) begin
            state_d = SPut;
          end else begin
            ptr_d   = ptr_q - plid_pkg::CntW'(1);
            state_d = SRead;
          end
        end
      end
      SPut: begin
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        ram_wdata = value_q;
        state_d   = SFin;
      end
      SFin: begin
        if (out_free) begin
          count_d                  = new_count;
          out_valid_d              = 1'b1;
          out_data_d.status        = status_q;
          out_data_d.removed_value = removed_q;
          out_data_d.list_length   = 7'(new_count);
          state_d                  = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    slot_q     <= slot_d;
    del_q      <= del_d;
    grow_q     <= grow_d;
    shrink_q   <= shrink_d;
    status_q   <= status_d;
    value_q    <= value_d;
    removed_q  <= removed_d;
    out_data_q <= out_data_d;
  end

  plid_ram #(
    .Width (plid_pkg::DataW),
    .Depth (plid_pkg::Capacity)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr[plid_pkg::AddrW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q[plid_pkg::AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
